// File: rtl/bounding_sphere_refine_core_assert.svh
// assertion macros for the bounding sphere refinement core
// used by the top level only, no other dependencies
`ifndef BOUNDING_SPHERE_REFINE_CORE_ASSERT_SVH
`define BOUNDING_SPHERE_REFINE_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bsr_pkg.sv
// shared constants for the bounding sphere refinement core
// no dependencies
package bsr_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam logic [1:0] REG_CX = 2'd0;
  localparam logic [1:0] REG_CY = 2'd1;
  localparam logic [1:0] REG_CZ = 2'd2;
  localparam logic [1:0] REG_R  = 2'd3;
endpackage

// File: rtl/bounding_sphere_refine_core.sv
// bounding sphere refinement: one request in, one shared add/sub unit does squares,
// square root, products and divisions bit-serially; no overlap between requests
// in_ready stays low from accept until the vertex is done, a shorter run when the vertex
// is inside since the product, division and rounding steps are skipped; a last vertex also
// passes the push state, which waits while an unaccepted result holds the output register;
// rst_n sync active low clears state and config
`include "bounding_sphere_refine_core_assert.svh"
module bounding_sphere_refine_core import bsr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_WIDTH-1:0]       cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_z,
  input  logic                         in_first_vertex,
  input  logic                         in_last_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_WIDTH-1:0] out_center_x,
  output logic signed [COORD_WIDTH-1:0] out_center_y,
  output logic signed [COORD_WIDTH-1:0] out_center_z,
  output logic [COORD_WIDTH-2:0]       out_radius
);
  localparam int CW = COORD_WIDTH;
  localparam int RW = CW - 1;
  localparam int DW = CW + 1;          // coordinate difference width
  localparam int SW = 2 * DW + 2;      // squared distance sum width
  localparam int QW = DW;              // root width
  localparam int NW = 2 * DW + 1;      // dividend width (|da| * grow)
  localparam int AW = NW + 2;          // shared adder width
  localparam int CNTW = $clog2(NW + 2);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;  // square accumulate, shift-add
  localparam logic [2:0] ST_ROOT = 3'd2;  // digit-by-digit square root
  localparam logic [2:0] ST_MUL  = 3'd3;  // |da| * grow, shift-add
  localparam logic [2:0] ST_DIV  = 3'd4;  // restoring division
  localparam logic [2:0] ST_RND  = 3'd5;  // rounding and centre update, radius after the last axis
  localparam logic [2:0] ST_OUT  = 3'd6;  // push result

  logic [2:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  // configuration
  logic signed [CW-1:0] cfg_cx_r, cfg_cy_r, cfg_cz_r;
  logic [RW-1:0] cfg_r_r;
  // sphere state
  logic signed [CW-1:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [RW-1:0] rad_r, rad_nxt;
  // working data
  logic signed [DW-1:0] dl_r [3];
  logic signed [DW-1:0] dl_nxt [3];
  logic last_r, last_nxt;
  logic [SW-1:0] acc_r, acc_nxt;       // square sum, later root remainder
  logic [DW-1:0] mc_r, mc_nxt;         // multiplicand / multiplier shift
  logic [NW-1:0] prod_r, prod_nxt;     // product, then dividend shift
  logic [QW-1:0] q_r, q_nxt;           // root, then quotient
  logic [QW-1:0] dist_r, dist_nxt;
  logic [DW:0] rem_r, rem_nxt;         // division remainder
  logic [DW:0] den_w;
  logic [DW-1:0] grow_w;

  // output register
  logic ov_r;
  logic signed [CW-1:0] ocx_r, ocy_r, ocz_r;
  logic [RW-1:0] orad_r;

  // the one shared adder/subtractor
  logic [AW-1:0] add_a, add_b, add_s;
  logic add_sub;
  assign add_s = add_sub ? (add_a - add_b) : (add_a + add_b);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_center_x = ocx_r;
  assign out_center_y = ocy_r;
  assign out_center_z = ocz_r;
  assign out_radius   = orad_r;

  assign den_w  = {dist_r, 1'b0};
  assign grow_w = dist_r - DW'(rad_r);

  // magnitude of the active axis difference
  logic signed [DW-1:0] da_w;
  logic [DW-1:0] mag_w;
  logic [DW+1:0] rem_shift;            // remainder can reach den, so one bit more
  assign da_w  = dl_r[axis_r];
  assign mag_w = da_w[DW-1] ? DW'(-da_w) : DW'(da_w);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; rad_nxt = rad_r;
    dl_nxt = dl_r;
    last_nxt = last_r;
    acc_nxt = acc_r; mc_nxt = mc_r; prod_nxt = prod_r;
    q_nxt = q_r; dist_nxt = dist_r; rem_nxt = rem_r;
    add_a = '0; add_b = '0; add_sub = 1'b0;
    rem_shift = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_first_vertex) begin
            dl_nxt[0] = DW'(in_vertex_x) - DW'(cfg_cx_r);
            dl_nxt[1] = DW'(in_vertex_y) - DW'(cfg_cy_r);
            dl_nxt[2] = DW'(in_vertex_z) - DW'(cfg_cz_r);
            cx_nxt = cfg_cx_r; cy_nxt = cfg_cy_r; cz_nxt = cfg_cz_r;
            rad_nxt = cfg_r_r;
          end else begin
            dl_nxt[0] = DW'(in_vertex_x) - DW'(cx_r);
            dl_nxt[1] = DW'(in_vertex_y) - DW'(cy_r);
            dl_nxt[2] = DW'(in_vertex_z) - DW'(cz_r);
          end
          // sign-extend inputs before subtract
          dl_nxt[0] = {in_vertex_x[CW-1], in_vertex_x} -
                      (in_first_vertex ? {cfg_cx_r[CW-1], cfg_cx_r} : {cx_r[CW-1], cx_r});
          dl_nxt[1] = {in_vertex_y[CW-1], in_vertex_y} -
                      (in_first_vertex ? {cfg_cy_r[CW-1], cfg_cy_r} : {cy_r[CW-1], cy_r});
          dl_nxt[2] = {in_vertex_z[CW-1], in_vertex_z} -
                      (in_first_vertex ? {cfg_cz_r[CW-1], cfg_cz_r} : {cz_r[CW-1], cz_r});
          last_nxt = in_last_vertex;
          acc_nxt = '0;
          axis_nxt = 2'd0;
          cnt_nxt = '0;
          prod_nxt = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        // square of axis by shift-add: bit cnt of magnitude
        if (cnt_r == '0) mc_nxt = mag_w;
        else mc_nxt = mc_r >> 1;
        add_a = AW'(acc_r);
        add_b = AW'({mag_w, {DW{1'b0}}} >> (DW - 32'(cnt_r)));
        if (((cnt_r == '0) ? mag_w[0] : mc_r[1]))
          acc_nxt = SW'(add_s);
        if (32'(cnt_r) == DW - 1) begin
          cnt_nxt = '0;
          if (axis_r == 2'd2) begin
            axis_nxt = 2'd0;
            q_nxt = '0;
            state_nxt = ST_ROOT;
          end else axis_nxt = axis_r + 2'd1;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      ST_ROOT: begin
        // trial root bit b = QW-1-cnt; acc holds n - q^2
        // take the bit when (2q + b) * b still fits in the remainder
        add_a = AW'(acc_r);
        add_b = AW'(((SW'(q_r) << 1) | SW'(1) << (QW - 1 - 32'(cnt_r)))
                    << (QW - 1 - 32'(cnt_r)));
        add_sub = 1'b1;
        if (!add_s[AW-1]) begin
          acc_nxt = SW'(add_s);
          q_nxt = q_r | (QW'(1) << (QW - 1 - 32'(cnt_r)));
        end
        if (32'(cnt_r) == QW - 1) begin
          cnt_nxt = '0;
          state_nxt = ST_MUL;
        end else cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == QW - 1) begin
          dist_nxt = (!add_s[AW-1]) ? (q_r | QW'(1)) : q_r;
          axis_nxt = 2'd0;
          prod_nxt = '0;
          if (((!add_s[AW-1]) ? (q_r | QW'(1)) : q_r) <= QW'(rad_r))
            state_nxt = last_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_MUL: begin
        // prod += grow << cnt when bit cnt of |da| set
        add_a = AW'(prod_r);
        add_b = AW'(NW'(grow_w) << cnt_r);
        if (mag_w[cnt_r[$clog2(DW)-1:0]]) prod_nxt = NW'(add_s);
        if (32'(cnt_r) == DW - 1) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          q_nxt = '0;
          state_nxt = ST_DIV;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      ST_DIV: begin
        rem_shift = {rem_r, prod_r[NW-1]};
        prod_nxt = prod_r << 1;
        add_a = AW'(rem_shift);
        add_b = AW'(den_w);
        add_sub = 1'b1;
        q_nxt = q_r << 1;
        rem_nxt = rem_shift[DW:0];
        if (!add_s[AW-1]) begin
          rem_nxt = (DW+1)'(add_s);
          q_nxt = (q_r << 1) | QW'(1);
        end
        if (32'(cnt_r) == NW - 1) begin
          cnt_nxt = '0;
          state_nxt = ST_RND;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      ST_RND: begin
        // round half up: rem >= den - rem, then signed step of the centre
        add_a = AW'({rem_r, 1'b0});
        add_b = AW'(den_w);
        add_sub = 1'b1;
        begin
          logic [QW-1:0] qr;
          qr = q_r + QW'(!add_s[AW-1]);
          case (axis_r)
            2'd0: cx_nxt = da_w[DW-1] ? CW'(cx_r - CW'(qr)) : CW'(cx_r + CW'(qr));
            2'd1: cy_nxt = da_w[DW-1] ? CW'(cy_r - CW'(qr)) : CW'(cy_r + CW'(qr));
            default: cz_nxt = da_w[DW-1] ? CW'(cz_r - CW'(qr)) : CW'(cz_r + CW'(qr));
          endcase
        end
        cnt_nxt = '0;
        prod_nxt = '0;
        if (axis_r == 2'd2) begin
          axis_nxt = 2'd0;
          begin
            logic [QW:0] nr;
            nr = ({1'b0, dist_r} + (QW+1)'(rad_r) + (QW+1)'(1)) >> 1;
            rad_nxt = (nr > (QW+1)'({RW{1'b1}})) ? {RW{1'b1}} : RW'(nr);
          end
          state_nxt = last_r ? ST_OUT : ST_IDLE;
        end else begin
          axis_nxt = axis_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r <= '0;
      cnt_r <= '0;
      cfg_cx_r <= '0; cfg_cy_r <= '0; cfg_cz_r <= '0; cfg_r_r <= '0;
      cx_r <= '0; cy_r <= '0; cz_r <= '0; rad_r <= '0;
      ov_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r <= axis_nxt;
      cnt_r <= cnt_nxt;
      cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; rad_r <= rad_nxt;
      last_r <= last_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CX: cfg_cx_r <= cfg_data;
          REG_CY: cfg_cy_r <= cfg_data;
          REG_CZ: cfg_cz_r <= cfg_data;
          REG_R:  cfg_r_r <= cfg_data[RW-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    acc_r <= acc_nxt; mc_r <= mc_nxt; prod_r <= prod_nxt;
    q_r <= q_nxt; dist_r <= dist_nxt; rem_r <= rem_nxt;
    if (state_r == ST_OUT && (!ov_r || out_ready)) begin
      ocx_r <= cx_r; ocy_r <= cy_r; ocz_r <= cz_r; orad_r <= rad_r;
    end
  end

  `BSR_ASSERT_IMPL(a_busy_not_ready, state_r != ST_IDLE, !in_ready, "ready while busy")
  `BSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `BSR_ASSERT_IMPL(a_axis_range, state_r != ST_IDLE, axis_r != 2'd3, "bad axis")
endmodule

// File: bench/tb_bounding_sphere_refine_core.sv
// self-checking bench for the bounding sphere refinement core
// holds its own sphere predictor; depends on bsr_pkg and the core RTL only
`timescale 1ns / 1ps

module tb_bounding_sphere_refine_core;
  import bsr_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic [63:0] RAD_MAX = 64'h7FFF_FFFF;
  localparam int SETTLE_CYCLES = 600;     // a bit over one full vertex computation
  localparam int WATCHDOG_LIMIT = 20000;  // idle cycles allowed, covers the long hold-off
  localparam int LONG_HOLD = 3000;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 197;
  localparam int EXP_DEPTH = 16;
  localparam int DIR_MAX = 16;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] r;
  } sphere_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          first;
    bit          last;
    bit          typed;   // expected sphere written in below
    sphere_t     sph;
  } vtx_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_CX;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_vertex_x = '0;
  logic signed [CW-1:0] in_vertex_y = '0;
  logic signed [CW-1:0] in_vertex_z = '0;
  logic in_first_vertex = 1'b0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_center_x;
  logic signed [CW-1:0] out_center_y;
  logic signed [CW-1:0] out_center_z;
  logic [CW-2:0] out_radius;

  // predictor state: configured sphere and running sphere
  logic signed [63:0] ini_cx, ini_cy, ini_cz;
  logic [63:0] ini_rad;
  logic signed [63:0] run_cx, run_cy, run_cz;
  logic [63:0] run_rad;

  // expected spheres in order, written by the sender and read by the checker
  sphere_t exp_mem [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit send_idle_on = 1'b0;
  bit recv_idle_on = 1'b0;
  bit long_hold_req = 1'b0;

  always #6 clk = ~clk;

  bounding_sphere_refine_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y), .in_vertex_z(in_vertex_z),
    .in_first_vertex(in_first_vertex), .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_center_z(out_center_z), .out_radius(out_radius)
  );

  // floor of the square root of a wide sum of squares
  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [63:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = {64'b0, r | (64'b1 << b)};
      if (t * t <= n) r = t[63:0];
    end
    return r;
  endfunction

  // move one centre axis by round(|da| * grow / den), ties away from zero
  function automatic logic signed [63:0] move_axis(input logic signed [63:0] c,
                                                   input logic signed [63:0] da,
                                                   input logic [63:0] grow,
                                                   input logic [63:0] den);
    logic [127:0] num, q, rem, dw;
    logic [63:0] m;
    m = (da < 0) ? -da : da;
    dw = {64'b0, den};
    num = {64'b0, m} * {64'b0, grow};
    q = num / dw;
    rem = num % dw;
    if (rem >= dw - rem) q = q + 1;
    return (da < 0) ? c - $signed(q[63:0]) : c + $signed(q[63:0]);
  endfunction

  // one vertex through the predictor; returns 1 when a sphere comes out
  function automatic bit refine_sphere(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z, input bit first,
                                       input bit last, output sphere_t sph);
    logic signed [63:0] dx, dy, dz;
    logic [63:0] mx, my, mz, d, grow, nr;
    logic [127:0] sum;
    if (first) begin
      run_cx = ini_cx; run_cy = ini_cy; run_cz = ini_cz; run_rad = ini_rad;
    end
    dx = 64'($signed(x)) - run_cx;
    dy = 64'($signed(y)) - run_cy;
    dz = 64'($signed(z)) - run_cz;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    mz = (dz < 0) ? -dz : dz;
    sum = {64'b0, mx} * {64'b0, mx} + {64'b0, my} * {64'b0, my} + {64'b0, mz} * {64'b0, mz};
    d = isqrt(sum);
    if (d > run_rad) begin
      grow = d - run_rad;
      nr = (d + run_rad + 1) >> 1;
      run_cx = move_axis(run_cx, dx, grow, d << 1);
      run_cy = move_axis(run_cy, dy, grow, d << 1);
      run_cz = move_axis(run_cz, dz, grow, d << 1);
      run_rad = (nr > RAD_MAX) ? RAD_MAX : nr;
    end
    sph.cx = run_cx[31:0];
    sph.cy = run_cy[31:0];
    sph.cz = run_cz[31:0];
    sph.r = run_rad[30:0];
    return last;
  endfunction

  // all four sphere registers in one burst; valid stays high between writes
  task automatic load_sphere_cfg(input logic [31:0] cx, input logic [31:0] cy,
                                 input logic [31:0] cz, input logic [30:0] r);
    logic [31:0] vals[4];
    logic [1:0] idx[4];
    vals = '{cx, cy, cz, {1'b0, r}};
    idx = '{REG_CX, REG_CY, REG_CZ, REG_R};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    ini_cx = $signed(cx); ini_cy = $signed(cy); ini_cz = $signed(cz);
    ini_rad = {33'b0, r};
  endtask

  // one vertex request; the expectation is logged at the accepting edge
  task automatic send_vertex(input vtx_row_t row);
    int gap;
    sphere_t sph;
    gap = send_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_x <= row.x;
    in_vertex_y <= row.y;
    in_vertex_z <= row.z;
    in_first_vertex <= row.first;
    in_last_vertex <= row.last;
    do @(posedge clk); while (!in_ready);
    if (refine_sphere(row.x, row.y, row.z, row.first, row.last, sph)) begin
      exp_mem[exp_wr % EXP_DEPTH] = row.typed ? row.sph : sph;
      exp_wr++;
    end
    @(negedge clk);
  endtask

  // sender pause: every sphere back, then time for a trailing no-result vertex
  task automatic drain_all;
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord(input logic signed [63:0] near);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return near[31:0] + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return near[31:0] + $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  // directed rows, typed expectations only where they are obvious
  vtx_row_t dir_rows [DIR_MAX];
  int n_dir = 0;

  function automatic void add_row(input vtx_row_t row);
    dir_rows[n_dir] = row;
    n_dir++;
  endfunction

  function automatic vtx_row_t mk(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input bit f, input bit l,
                                  input bit typed = 1'b0, input sphere_t sph = '0);
    vtx_row_t row;
    row.x = x; row.y = y; row.z = z; row.first = f; row.last = l;
    row.typed = typed; row.sph = sph;
    return row;
  endfunction

  // sender: reset, directed table, random phases, end of run
  initial begin
    vtx_row_t row;
    int set_len;
    ini_cx = 0; ini_cy = 0; ini_cz = 0; ini_rad = 0;
    run_cx = 0; run_cy = 0; run_cz = 0; run_rad = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers still at reset: zero sphere
    add_row(mk(0, 0, 0, 1, 1, 1, '{0, 0, 0, 0}));
    add_row(mk(32'h1_0000, 0, 0, 1, 1, 1, '{32'h8000, 0, 0, 31'h8000}));
    // set without a first vertex continues from the last sphere
    add_row(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    add_row(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1));
    add_row(mk(0, 0, 0, 0, 1));
    // after the first config: origin, maximum radius
    add_row(mk(0, 0, 0, 1, 1, 1, '{0, 0, 0, 31'h7FFF_FFFF}));
    add_row(mk(32'h7FFF_FFFF, 0, 0, 1, 1, 1, '{0, 0, 0, 31'h7FFF_FFFF}));
    add_row(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0));
    add_row(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1));
    add_row(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
    // after the second config: corner centre, zero radius
    add_row(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1,
               '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0}));
    add_row(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1));
    add_row(mk(32'h7FFF_0000, 32'h8000_1234, 32'h7FFF_FFFF, 1, 0));
    add_row(mk(32'h0000_0001, 32'h8000_0000, 32'h0000_0000, 0, 0));
    add_row(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    add_row(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 0, 1));

    for (int i = 0; i < n_dir; i++) begin
      if (i == 5) begin
        drain_all();
        load_sphere_cfg(0, 0, 0, 31'h7FFF_FFFF);
      end else if (i == 10) begin
        drain_all();
        load_sphere_cfg(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
      end
      send_vertex(dir_rows[i]);
    end

    // random phases: fresh config each time, varied idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_all();
      case (ph % 4)
        0: load_sphere_cfg($urandom, $urandom, $urandom, 31'($urandom));
        1: load_sphere_cfg($urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                           $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                           $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                           31'($urandom_range(0, 32'h0010_0000)));
        2: load_sphere_cfg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
        default: load_sphere_cfg(32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF);
      endcase
      send_idle_on = (ph % 3) != 2;
      recv_idle_on = (ph % 2) == 0;
      // receiver stalls long while requests keep coming
      if (ph == 3) long_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n += set_len) begin
        set_len = $urandom_range(1, 8);
        for (int k = 0; k < set_len; k++) begin
          // mostly well-formed sets, some open-ended or continuing ones
          row = mk(pick_coord(run_cx), pick_coord(run_cy), pick_coord(run_cz),
                   (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                   (k == set_len - 1) ? ($urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 19) == 0));
          send_vertex(row);
        end
      end
    end

    drain_all();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    int hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = recv_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // result check against the oldest expected sphere
  always @(posedge clk) begin
    sphere_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: sphere with none expected: %h %h %h %h", $time,
                 out_center_x, out_center_y, out_center_z, out_radius);
        errors++;
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_center_x !== want.cx) begin
          $display("%0t: center_x expected %h actual %h", $time, want.cx, out_center_x);
          errors++;
        end
        if (out_center_y !== want.cy) begin
          $display("%0t: center_y expected %h actual %h", $time, want.cy, out_center_y);
          errors++;
        end
        if (out_center_z !== want.cz) begin
          $display("%0t: center_z expected %h actual %h", $time, want.cz, out_center_z);
          errors++;
        end
        if (out_radius !== want.r) begin
          $display("%0t: radius expected %h actual %h", $time, want.r, out_radius);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
